// ===== rtl/core/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants for the topological sort engine
// Item and result structs, command and status codes, memory sizes.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int NODE_W    = 6;
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam int EDGE_AW   = 8;   // edge store address bits
    localparam int ECNT_W    = 9;   // edge count, holds MAX_EDGES itself
    localparam int DEG_W     = 9;   // in-degree, at most MAX_EDGES
    localparam int QCNT_W    = 7;   // queue head/tail, holds MAX_NODES itself

    typedef enum logic [1:0] {
        FUNC_NODE = 2'd0,
        FUNC_EDGE = 2'd1,
        FUNC_RUN  = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_ORDER    = 2'd0,
        ST_CYCLE    = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [1:0]        status;
        logic              last;
    } out_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_TAKE,
        CMD_INC,
        CMD_SCAN_RD,
        CMD_SCAN_CHK,
        CMD_POP_RD,
        CMD_POP_LOAD,
        CMD_EDGE_RD,
        CMD_EDGE_CHK,
        CMD_DEC,
        CMD_EMIT_INIT,
        CMD_EMIT_RD,
        CMD_EMIT_OUT,
        CMD_STAT,
        CMD_CLEAR
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;       // func of the item on the input channel
        logic       full;       // edge store full
        logic       overflow;   // an edge was dropped since the last run
        logic       scan_done;  // scan index at the last node
        logic       cnt_zero;   // no present node
        logic       q_empty;    // queue head caught up with tail
        logic       e_done;     // edge index reached edge count
        logic       src_match;  // fetched edge leaves the current node
        logic       mismatch;   // ordered count differs from present count
        logic       emit_last;  // emit index at the final queue entry
        logic       out_busy;   // output register cannot take a result
    } stat_t;

endpackage

// ===== rtl/core/topological_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// topological_sort_engine_core: Kahn topological sort over a loaded graph
// Takes node/edge/run transactions and streams the sorted order or a status.
// ----------------------------------------------------------------------------
// A declare-node transaction is taken alone; an add-edge transaction adds an
// S_INC step (read-modify-write of the in-degree memory). A run transaction
// blocks input during a zero-in-degree scan of every node slot (read, check),
// then per queued node a pop and a load plus a read and a check per stored
// edge (a decrement on a match), since every pop walks the whole edge store
// through its single read port; then a read and an output step per emitted
// node plus any output stall, and a graph clear. An overflowed edge store
// reports status 3 right away. Results leave through an output register, so
// the next load transaction is taken while the final result still waits.
module topological_sort_engine_core (
    input  logic          aclk,
    input  logic          aresetn,
    // input transactions
    input  logic          s_valid,
    output logic          s_ready,
    input  tse_pkg::in_t  s_data,
    // result transactions
    output logic          m_valid,
    input  logic          m_ready,
    output tse_pkg::out_t m_data
);

    tse_pkg::cmd_t  cmd;
    tse_pkg::stat_t stat;

    // sequencer: one command per cycle to the datapath
    tse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memories, counters and output register
    tse_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/tse_ctrl.sv =====
// ----------------------------------------------------------------------------
// tse_ctrl: sequencer for the topological sort engine
// Steps load, scan, pop/relax, check and emit phases; issues datapath commands.
// ----------------------------------------------------------------------------
module tse_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tse_pkg::stat_t stat,
    output tse_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_POP,
        S_POP_LOAD,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_DEC,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_STAT,
        S_CLEAR
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = tse_pkg::CMD_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd = tse_pkg::CMD_TAKE;
                    if (stat.func == tse_pkg::FUNC_EDGE && !stat.full) begin
                        state_next = S_INC;
                    end else if (stat.func == tse_pkg::FUNC_RUN) begin
                        state_next = stat.overflow ? S_STAT : S_SCAN_RD;
                    end
                end
            end
            S_INC: begin
                cmd        = tse_pkg::CMD_INC;
                state_next = S_IDLE;
            end
            S_SCAN_RD: begin
                cmd        = tse_pkg::CMD_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                cmd        = tse_pkg::CMD_SCAN_CHK;
                state_next = stat.scan_done ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END: begin
                state_next = stat.cnt_zero ? S_STAT : S_POP;
            end
            S_POP: begin
                if (stat.q_empty) begin
                    state_next = S_CHECK;
                end else begin
                    cmd        = tse_pkg::CMD_POP_RD;
                    state_next = S_POP_LOAD;
                end
            end
            S_POP_LOAD: begin
                cmd        = tse_pkg::CMD_POP_LOAD;
                state_next = S_EDGE_RD;
            end
            S_EDGE_RD: begin
                if (stat.e_done) begin
                    state_next = S_POP;
                end else begin
                    cmd        = tse_pkg::CMD_EDGE_RD;
                    state_next = S_EDGE_CHK;
                end
            end
            S_EDGE_CHK: begin
                cmd        = tse_pkg::CMD_EDGE_CHK;
                state_next = stat.src_match ? S_DEC : S_EDGE_RD;
            end
            S_DEC: begin
                cmd        = tse_pkg::CMD_DEC;
                state_next = S_EDGE_RD;
            end
            S_CHECK: begin
                if (stat.mismatch) begin
                    state_next = S_STAT;
                end else begin
                    cmd        = tse_pkg::CMD_EMIT_INIT;
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                cmd        = tse_pkg::CMD_EMIT_RD;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (!stat.out_busy) begin
                    cmd        = tse_pkg::CMD_EMIT_OUT;
                    state_next = stat.emit_last ? S_CLEAR : S_EMIT_RD;
                end
            end
            S_STAT: begin
                if (!stat.out_busy) begin
                    cmd        = tse_pkg::CMD_STAT;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cmd        = tse_pkg::CMD_CLEAR;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/tse_dp.sv =====
// ----------------------------------------------------------------------------
// tse_dp: datapath of the topological sort engine
// Edge store, in-degree memory, order queue, counters and output register.
// ----------------------------------------------------------------------------
module tse_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  tse_pkg::cmd_t  cmd,
    output tse_pkg::stat_t stat,
    input  tse_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tse_pkg::out_t  m_data
);

    typedef struct packed {
        logic [tse_pkg::NODE_W-1:0] src;
        logic [tse_pkg::NODE_W-1:0] dst;
    } edge_t;

    localparam logic [tse_pkg::NODE_W-1:0] LAST_NODE = '1;

    // storage
    edge_t                      edge_mem [tse_pkg::MAX_EDGES];
    logic [tse_pkg::DEG_W-1:0]  deg_mem  [tse_pkg::MAX_NODES];
    logic [tse_pkg::NODE_W-1:0] q_mem    [tse_pkg::MAX_NODES];

    edge_t                       edge_rdata_reg;
    logic [tse_pkg::DEG_W-1:0]   deg_rdata_reg;
    logic                        deg_vld_reg;
    logic [tse_pkg::NODE_W-1:0]  q_rdata_reg;

    logic [tse_pkg::MAX_NODES-1:0] present_reg, present_next;
    logic [tse_pkg::MAX_NODES-1:0] dvalid_reg, dvalid_next;
    logic [tse_pkg::ECNT_W-1:0]    ecnt_reg, ecnt_next;
    logic                          ovf_reg, ovf_next;
    logic [tse_pkg::NODE_W-1:0]    dst_reg, dst_next;
    logic [tse_pkg::NODE_W-1:0]    n_reg, n_next;
    logic [tse_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic [tse_pkg::QCNT_W-1:0]    head_reg, head_next;
    logic [tse_pkg::QCNT_W-1:0]    tail_reg, tail_next;
    logic [tse_pkg::ECNT_W-1:0]    e_reg, e_next;
    logic [tse_pkg::NODE_W-1:0]    cur_reg, cur_next;
    logic                          mval_reg, mval_next;
    tse_pkg::out_t                 out_reg, out_next;

    logic [tse_pkg::DEG_W-1:0]  deg_eff;
    logic                       deg_re, deg_we;
    logic [tse_pkg::NODE_W-1:0] deg_raddr, deg_waddr;
    logic [tse_pkg::DEG_W-1:0]  deg_wdata;
    logic                       q_we, q_re;
    logic [tse_pkg::NODE_W-1:0] q_raddr;
    logic                       e_we, e_re;
    logic                       tail_room;
    tse_pkg::func_t             func;

    assign func      = tse_pkg::func_t'(s_data.func);
    assign deg_eff   = deg_vld_reg ? deg_rdata_reg : '0;
    assign tail_room = (tail_reg != tse_pkg::QCNT_W'(tse_pkg::MAX_NODES));

    assign stat.func      = s_data.func;
    assign stat.full      = (ecnt_reg == tse_pkg::ECNT_W'(tse_pkg::MAX_EDGES));
    assign stat.overflow  = ovf_reg;
    assign stat.scan_done = (n_reg == LAST_NODE);
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.q_empty   = (head_reg == tail_reg);
    assign stat.e_done    = (e_reg == ecnt_reg);
    assign stat.src_match = (edge_rdata_reg.src == cur_reg);
    assign stat.mismatch  = (tail_reg != cnt_reg);
    assign stat.emit_last = ((tse_pkg::QCNT_W'(n_reg) + 1'b1) == tail_reg);
    assign stat.out_busy  = mval_reg & ~m_ready;

    assign m_valid = mval_reg;
    assign m_data  = out_reg;

    always_comb begin
        present_next = present_reg;
        dvalid_next  = dvalid_reg;
        ecnt_next    = ecnt_reg;
        ovf_next     = ovf_reg;
        dst_next     = dst_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        e_next       = e_reg;
        cur_next     = cur_reg;
        mval_next    = mval_reg & ~m_ready;
        out_next     = out_reg;
        deg_re       = 1'b0;
        deg_raddr    = edge_rdata_reg.dst;
        deg_we       = 1'b0;
        deg_waddr    = dst_reg;
        deg_wdata    = deg_eff + 1'b1;
        q_we         = 1'b0;
        q_re         = 1'b0;
        q_raddr      = n_reg;
        e_we         = 1'b0;
        e_re         = 1'b0;
        unique case (cmd)
            tse_pkg::CMD_TAKE: begin
                deg_re    = 1'b1;
                deg_raddr = s_data.dst_node;
                unique case (func)
                    tse_pkg::FUNC_NODE: present_next[s_data.src_node] = 1'b1;
                    tse_pkg::FUNC_EDGE: begin
                        present_next[s_data.src_node] = 1'b1;
                        present_next[s_data.dst_node] = 1'b1;
                        dst_next = s_data.dst_node;
                        if (stat.full) begin
                            ovf_next = 1'b1;
                        end else begin
                            e_we      = 1'b1;
                            ecnt_next = ecnt_reg + 1'b1;
                        end
                    end
                    tse_pkg::FUNC_RUN: begin
                        n_next    = '0;
                        cnt_next  = '0;
                        head_next = '0;
                        tail_next = '0;
                    end
                    default: ;
                endcase
            end
            tse_pkg::CMD_INC: begin
                deg_we = 1'b1;
                dvalid_next[dst_reg] = 1'b1;
            end
            tse_pkg::CMD_SCAN_RD: begin
                deg_re    = 1'b1;
                deg_raddr = n_reg;
            end
            tse_pkg::CMD_SCAN_CHK: begin
                if (present_reg[n_reg]) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (deg_eff == '0 && tail_room) begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                n_next = n_reg + 1'b1;
            end
            tse_pkg::CMD_POP_RD: begin
                q_re      = 1'b1;
                q_raddr   = head_reg[tse_pkg::NODE_W-1:0];
                head_next = head_reg + 1'b1;
            end
            tse_pkg::CMD_POP_LOAD: begin
                cur_next = q_rdata_reg;
                e_next   = '0;
            end
            tse_pkg::CMD_EDGE_RD: e_re = 1'b1;
            tse_pkg::CMD_EDGE_CHK: begin
                if (stat.src_match) begin
                    deg_re = 1'b1;
                end else begin
                    e_next = e_reg + 1'b1;
                end
            end
            tse_pkg::CMD_DEC: begin
                // already-zero destinations are skipped
                if (deg_eff != '0) begin
                    deg_we    = 1'b1;
                    deg_waddr = edge_rdata_reg.dst;
                    deg_wdata = deg_eff - 1'b1;
                    dvalid_next[edge_rdata_reg.dst] = 1'b1;
                    if (deg_eff == tse_pkg::DEG_W'(1) && tail_room) begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                e_next = e_reg + 1'b1;
            end
            tse_pkg::CMD_EMIT_INIT: n_next = '0;
            tse_pkg::CMD_EMIT_RD:   q_re = 1'b1;
            tse_pkg::CMD_EMIT_OUT: begin
                mval_next       = 1'b1;
                out_next.node   = q_rdata_reg;
                out_next.status = tse_pkg::ST_ORDER;
                out_next.last   = stat.emit_last;
                n_next          = n_reg + 1'b1;
            end
            tse_pkg::CMD_STAT: begin
                mval_next     = 1'b1;
                out_next.node = '0;
                out_next.last = 1'b1;
                priority if (ovf_reg) begin
                    out_next.status = tse_pkg::ST_OVERFLOW;
                end else if (cnt_reg == '0) begin
                    out_next.status = tse_pkg::ST_EMPTY;
                end else begin
                    out_next.status = tse_pkg::ST_CYCLE;
                end
            end
            tse_pkg::CMD_CLEAR: begin
                present_next = '0;
                dvalid_next  = '0;
                ecnt_next    = '0;
                ovf_next     = 1'b0;
            end
            default: ;
        endcase
    end

    // queue write address is the tail; scan pushes n, relax pushes the edge target
    logic [tse_pkg::NODE_W-1:0] q_wdata;
    assign q_wdata = (cmd == tse_pkg::CMD_DEC) ? edge_rdata_reg.dst : n_reg;

    always_ff @(posedge aclk) begin
        if (e_we) begin
            edge_mem[ecnt_reg[tse_pkg::EDGE_AW-1:0]] <= '{src: s_data.src_node,
                                                          dst: s_data.dst_node};
        end
        if (e_re) begin
            edge_rdata_reg <= edge_mem[e_reg[tse_pkg::EDGE_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re) begin
            deg_rdata_reg <= deg_mem[deg_raddr];
            deg_vld_reg   <= dvalid_reg[deg_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[tail_reg[tse_pkg::NODE_W-1:0]] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= q_mem[q_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            dvalid_reg  <= '0;
            ecnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            mval_reg    <= 1'b0;
            n_reg       <= '0;
            cnt_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            e_reg       <= '0;
        end else begin
            present_reg <= present_next;
            dvalid_reg  <= dvalid_next;
            ecnt_reg    <= ecnt_next;
            ovf_reg     <= ovf_next;
            mval_reg    <= mval_next;
            n_reg       <= n_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            e_reg       <= e_next;
        end
    end

    always_ff @(posedge aclk) begin
        dst_reg <= dst_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule
